FILE: hw/rtl/tpfifo_pkg.sv
// shared types and constants for the two-level priority task fifo
// used by tpfifo_ctrl, tpfifo_dp and two_level_priority_task_fifo
package tpfifo_pkg;

  localparam int NORMAL_DEPTH  = 64;
  localparam int RECEIVE_DEPTH = 64;
  localparam int MAX_BUDGET    = 32;

  localparam int NPTR_W  = $clog2(NORMAL_DEPTH);
  localparam int RPTR_W  = $clog2(RECEIVE_DEPTH);
  localparam int NFILL_W = $clog2(NORMAL_DEPTH + 1);
  localparam int RFILL_W = $clog2(RECEIVE_DEPTH + 1);
  localparam int CNT_W   = $clog2(MAX_BUDGET + 1);
  localparam int CFG_W   = 6;
  localparam int WORD_W  = 32;

  localparam logic [CFG_W-1:0] BUDGET_RESET = CFG_W'(32);

  typedef enum logic [1:0] {
    CMD_POST_NORMAL  = 2'd0,
    CMD_POST_RECEIVE = 2'd1,
    CMD_DRAIN        = 2'd2,
    CMD_UNUSED       = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_INVALID = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POST,
    S_DRAIN_RD,
    S_DRAIN_WR
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic do_post;
    logic issue_pop;
    logic load_pop;
    logic load_empty;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic both_empty;
    logic pop_last;
  } dp_sts_t;

endpackage

FILE: hw/rtl/tpfifo_ctrl.sv
// controller state machine for the two-level priority task fifo
// depends on tpfifo_pkg
module tpfifo_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_command,
  output logic                  in_stall,
  input  tpfifo_pkg::dp_sts_t   sts,
  output tpfifo_pkg::ctrl_cmd_t cmd
);

  tpfifo_pkg::state_t state_r;
  tpfifo_pkg::state_t state_nxt;
  tpfifo_pkg::command_t in_cmd;

  assign in_cmd = tpfifo_pkg::command_t'(in_command);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpfifo_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpfifo_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            tpfifo_pkg::CMD_POST_NORMAL,
            tpfifo_pkg::CMD_POST_RECEIVE: state_nxt = tpfifo_pkg::S_POST;
            tpfifo_pkg::CMD_DRAIN:        state_nxt = tpfifo_pkg::S_DRAIN_RD;
            default:                      state_nxt = tpfifo_pkg::S_IDLE;
          endcase
        end
      end
      tpfifo_pkg::S_POST: begin
        if (sts.slot_free) state_nxt = tpfifo_pkg::S_IDLE;
      end
      tpfifo_pkg::S_DRAIN_RD: begin
        if (!sts.both_empty) begin
          state_nxt = tpfifo_pkg::S_DRAIN_WR;
        end else if (sts.slot_free) begin
          state_nxt = tpfifo_pkg::S_IDLE;
        end
      end
      tpfifo_pkg::S_DRAIN_WR: begin
        if (sts.slot_free) begin
          state_nxt = sts.pop_last ? tpfifo_pkg::S_IDLE : tpfifo_pkg::S_DRAIN_RD;
        end
      end
      default: state_nxt = tpfifo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      tpfifo_pkg::S_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_in = in_valid;
      end
      tpfifo_pkg::S_POST: begin
        cmd.do_post = sts.slot_free;
      end
      tpfifo_pkg::S_DRAIN_RD: begin
        cmd.issue_pop  = !sts.both_empty;
        cmd.load_empty = sts.both_empty && sts.slot_free;
      end
      tpfifo_pkg::S_DRAIN_WR: begin
        cmd.load_pop = sts.slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: hw/rtl/tpfifo_dp.sv
// datapath: both entry stores, pointers, fill counts, budget and result register
// depends on tpfifo_pkg
module tpfifo_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tpfifo_pkg::ctrl_cmd_t          cmd,
  output tpfifo_pkg::dp_sts_t            sts,
  input  logic [1:0]                     in_command,
  input  logic [tpfifo_pkg::WORD_W-1:0]  in_task_handle,
  input  logic [tpfifo_pkg::WORD_W-1:0]  in_task_arg,
  input  logic                           cfg_wr_en,
  input  logic [tpfifo_pkg::CFG_W-1:0]   cfg_wr_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [tpfifo_pkg::WORD_W-1:0]  out_handle,
  output logic [tpfifo_pkg::WORD_W-1:0]  out_arg,
  output logic                           out_from_receive,
  output logic                           out_last
);

  localparam int W  = tpfifo_pkg::WORD_W;
  localparam int EW = 2 * tpfifo_pkg::WORD_W;

  logic [EW-1:0] nrm_mem [tpfifo_pkg::NORMAL_DEPTH];
  logic [EW-1:0] rcv_mem [tpfifo_pkg::RECEIVE_DEPTH];

  logic [1:0]   cmd_r;
  logic [W-1:0] hdl_r;
  logic [W-1:0] arg_r;

  logic [tpfifo_pkg::NPTR_W-1:0]  nrm_wpos_r, nrm_wpos_nxt, nrm_rpos_r, nrm_rpos_nxt;
  logic [tpfifo_pkg::RPTR_W-1:0]  rcv_wpos_r, rcv_wpos_nxt, rcv_rpos_r, rcv_rpos_nxt;
  logic [tpfifo_pkg::NFILL_W-1:0] nrm_fill_r, nrm_fill_nxt;
  logic [tpfifo_pkg::RFILL_W-1:0] rcv_fill_r, rcv_fill_nxt;
  logic [tpfifo_pkg::CFG_W-1:0]   budget_r;
  logic [tpfifo_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, eff_budget;
  logic [tpfifo_pkg::CFG_W:0]     bud_ext;

  logic [EW-1:0] nrm_rd_r, rcv_rd_r;
  logic          src_r;
  logic          last_r;

  logic          out_valid_r;
  logic [1:0]    status_r;
  logic [W-1:0]  ohdl_r;
  logic [W-1:0]  oarg_r;
  logic          orcv_r;
  logic          olast_r;

  logic          to_receive;
  logic          q_full;
  logic [1:0]    post_status;
  logic          nrm_we, rcv_we, pop_rcv, pop_nrm, pop_last_nxt;
  logic [EW-1:0] pop_entry;

  // budget clamp
  always_comb begin
    bud_ext = {1'b0, budget_r};
    if (bud_ext == '0) begin
      eff_budget = tpfifo_pkg::CNT_W'(1);
    end else if (bud_ext > (tpfifo_pkg::CFG_W + 1)'(tpfifo_pkg::MAX_BUDGET)) begin
      eff_budget = tpfifo_pkg::CNT_W'(tpfifo_pkg::MAX_BUDGET);
    end else begin
      eff_budget = tpfifo_pkg::CNT_W'(bud_ext);
    end
  end

  assign to_receive = (tpfifo_pkg::command_t'(cmd_r) == tpfifo_pkg::CMD_POST_RECEIVE);
  assign q_full = to_receive
      ? (rcv_fill_r == tpfifo_pkg::RFILL_W'(tpfifo_pkg::RECEIVE_DEPTH))
      : (nrm_fill_r == tpfifo_pkg::NFILL_W'(tpfifo_pkg::NORMAL_DEPTH));

  always_comb begin
    priority if (hdl_r == '0) begin
      post_status = tpfifo_pkg::ST_INVALID;
    end else if (q_full) begin
      post_status = tpfifo_pkg::ST_BUSY;
    end else begin
      post_status = tpfifo_pkg::ST_OK;
    end
  end

  assign nrm_we  = cmd.do_post && !to_receive && (post_status == tpfifo_pkg::ST_OK);
  assign rcv_we  = cmd.do_post && to_receive && (post_status == tpfifo_pkg::ST_OK);
  assign pop_rcv = cmd.issue_pop && (rcv_fill_r != '0);
  assign pop_nrm = cmd.issue_pop && (rcv_fill_r == '0);

  // last pop: budget reached or this takes the only entry left
  assign pop_last_nxt = (tpfifo_pkg::CNT_W'(cnt_r + 1'b1) == eff_budget)
      || ((rcv_fill_r == tpfifo_pkg::RFILL_W'(1)) && (nrm_fill_r == '0))
      || ((rcv_fill_r == '0) && (nrm_fill_r == tpfifo_pkg::NFILL_W'(1)));

  always_comb begin
    nrm_wpos_nxt = nrm_wpos_r;
    nrm_rpos_nxt = nrm_rpos_r;
    nrm_fill_nxt = nrm_fill_r;
    rcv_wpos_nxt = rcv_wpos_r;
    rcv_rpos_nxt = rcv_rpos_r;
    rcv_fill_nxt = rcv_fill_r;
    cnt_nxt      = cnt_r;
    if (nrm_we) begin
      nrm_wpos_nxt = (nrm_wpos_r == tpfifo_pkg::NPTR_W'(tpfifo_pkg::NORMAL_DEPTH - 1))
          ? '0 : nrm_wpos_r + 1'b1;
      nrm_fill_nxt = nrm_fill_r + 1'b1;
    end
    if (rcv_we) begin
      rcv_wpos_nxt = (rcv_wpos_r == tpfifo_pkg::RPTR_W'(tpfifo_pkg::RECEIVE_DEPTH - 1))
          ? '0 : rcv_wpos_r + 1'b1;
      rcv_fill_nxt = rcv_fill_r + 1'b1;
    end
    if (pop_nrm) begin
      nrm_rpos_nxt = (nrm_rpos_r == tpfifo_pkg::NPTR_W'(tpfifo_pkg::NORMAL_DEPTH - 1))
          ? '0 : nrm_rpos_r + 1'b1;
      nrm_fill_nxt = nrm_fill_r - 1'b1;
    end
    if (pop_rcv) begin
      rcv_rpos_nxt = (rcv_rpos_r == tpfifo_pkg::RPTR_W'(tpfifo_pkg::RECEIVE_DEPTH - 1))
          ? '0 : rcv_rpos_r + 1'b1;
      rcv_fill_nxt = rcv_fill_r - 1'b1;
    end
    if (cmd.latch_in) begin
      cnt_nxt = '0;
    end else if (cmd.issue_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_wpos_r <= '0;
      nrm_rpos_r <= '0;
      nrm_fill_r <= '0;
      rcv_wpos_r <= '0;
      rcv_rpos_r <= '0;
      rcv_fill_r <= '0;
      cnt_r      <= '0;
      budget_r   <= tpfifo_pkg::BUDGET_RESET;
    end else begin
      nrm_wpos_r <= nrm_wpos_nxt;
      nrm_rpos_r <= nrm_rpos_nxt;
      nrm_fill_r <= nrm_fill_nxt;
      rcv_wpos_r <= rcv_wpos_nxt;
      rcv_rpos_r <= rcv_rpos_nxt;
      rcv_fill_r <= rcv_fill_nxt;
      cnt_r      <= cnt_nxt;
      if (cfg_wr_en) budget_r <= cfg_wr_data;
    end
  end

  // entry stores
  always_ff @(posedge clk) begin
    if (nrm_we) nrm_mem[nrm_wpos_r] <= {hdl_r, arg_r};
    if (cmd.issue_pop) nrm_rd_r <= nrm_mem[nrm_rpos_r];
  end

  always_ff @(posedge clk) begin
    if (rcv_we) rcv_mem[rcv_wpos_r] <= {hdl_r, arg_r};
    if (cmd.issue_pop) rcv_rd_r <= rcv_mem[rcv_rpos_r];
  end

  // input item and pop bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r <= in_command;
      hdl_r <= in_task_handle;
      arg_r <= in_task_arg;
    end
    if (cmd.issue_pop) begin
      src_r  <= pop_rcv;
      last_r <= pop_last_nxt;
    end
  end

  assign pop_entry = src_r ? rcv_rd_r : nrm_rd_r;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.do_post || cmd.load_pop || cmd.load_empty) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_post) begin
      status_r <= post_status;
      ohdl_r   <= '0;
      oarg_r   <= '0;
      orcv_r   <= 1'b0;
      olast_r  <= 1'b1;
    end else if (cmd.load_empty) begin
      status_r <= tpfifo_pkg::ST_EMPTY;
      ohdl_r   <= '0;
      oarg_r   <= '0;
      orcv_r   <= 1'b0;
      olast_r  <= 1'b1;
    end else if (cmd.load_pop) begin
      status_r <= tpfifo_pkg::ST_OK;
      ohdl_r   <= pop_entry[EW-1:W];
      oarg_r   <= pop_entry[W-1:0];
      orcv_r   <= src_r;
      olast_r  <= last_r;
    end
  end

  assign sts.slot_free  = !out_valid_r || !out_stall;
  assign sts.both_empty = (rcv_fill_r == '0) && (nrm_fill_r == '0);
  assign sts.pop_last   = last_r;

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_handle       = ohdl_r;
  assign out_arg          = oarg_r;
  assign out_from_receive = orcv_r;
  assign out_last         = olast_r;

endmodule

FILE: hw/rtl/two_level_priority_task_fifo.sv
// post: the item is latched in S_IDLE, then the result register is loaded in S_POST once the result slot is free
// drain: each popped entry takes a store read in S_DRAIN_RD, then a result register load in S_DRAIN_WR
// empty drain: one ST_EMPTY result, loaded once the result slot is free; out_stall can hold it back
// reset: pointers and fill counts cleared, budget set to 32, stores left uninitialized
// top level of the two-level priority task fifo
// depends on tpfifo_pkg, tpfifo_ctrl, tpfifo_dp
module two_level_priority_task_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [tpfifo_pkg::WORD_W-1:0]  in_task_handle,
  input  logic [tpfifo_pkg::WORD_W-1:0]  in_task_arg,
  input  logic                           cfg_wr_en,
  input  logic [tpfifo_pkg::CFG_W-1:0]   cfg_wr_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [tpfifo_pkg::WORD_W-1:0]  out_handle,
  output logic [tpfifo_pkg::WORD_W-1:0]  out_arg,
  output logic                           out_from_receive,
  output logic                           out_last
);

  tpfifo_pkg::ctrl_cmd_t cmd;
  tpfifo_pkg::dp_sts_t   sts;

  tpfifo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  tpfifo_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_command),
    .in_task_handle   (in_task_handle),
    .in_task_arg      (in_task_arg),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_handle       (out_handle),
    .out_arg          (out_arg),
    .out_from_receive (out_from_receive),
    .out_last         (out_last)
  );

`ifndef ASSERT_OFF
  a_nonok_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_status != tpfifo_pkg::ST_OK)
      |-> (out_handle == '0) && (out_arg == '0) && !out_from_receive && out_last)
    else $error("non-ok result carries a payload or is not last");

  a_ok_pop_handle: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_status == tpfifo_pkg::ST_OK) && (out_handle != '0)
      |-> !(cmd.do_post || cmd.load_empty) || !out_stall)
    else $error("result register overwritten while stalled");

  a_reset_quiet: assert property (@(posedge clk)
      $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
      $countones({cmd.latch_in, cmd.do_post, cmd.issue_pop, cmd.load_pop,
                  cmd.load_empty}) <= 1)
    else $error("controller issued more than one action");
`endif

endmodule
